// ----- src/sha_pkg.sv -----
// Shared types, constants and round functions for the SHA-256 stream hasher.
// Depends on nothing; every other file in src imports it.
`timescale 1ns / 1ps

package sha_pkg;

	// One input word: a message byte or a finish marker
	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} msg_t;

	// One output word: a digest word with its position
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_t;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam logic [5:0] FILL_LAST   = 6'd63;
	localparam logic [5:0] LEN_START   = 6'd56;
	localparam logic [5:0] ROUND_LAST  = 6'd63;
	localparam logic [2:0] WORD_LAST   = 3'd7;
	localparam logic [7:0] PAD_MARKER  = 8'h80;
	localparam logic [63:0] BITS_PER_BYTE = 64'd8;

	// Initial hash value, entry 0 is H0
	localparam logic [7:0][31:0] H_INIT = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic       load_data;
		logic       load_pad;
		logic       round;
		logic [5:0] rnd;
		logic       add;
		logic       out_shift;
		logic       init;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic fill_last;
		logic len_byte;
	} sts_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	// Round constants
	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		unique case (t)
			6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		round_k = k;
	endfunction

endpackage

// ----- src/sha_dp.sv -----
// Datapath: block line, message schedule, working variables, hash words.
// Depends on sha_pkg for types, round constants and round functions.
`timescale 1ns / 1ps

module sha_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  sha_pkg::cmd_t  cmd,
	input  logic [7:0]     data_byte,
	output sha_pkg::sts_t  sts,
	output logic [31:0]    hash_head
);
	import sha_pkg::*;

	logic [511:0]      line_q;     // 64 bytes, later 16 schedule words, oldest on top
	logic [5:0]        fill_q;
	logic [63:0]       bits_q;
	logic              marker_q;   // pad marker already placed
	logic              pad_extra_q; // marker landed in the length field before the last slot
	logic [7:0][31:0]  hash_q;
	logic [7:0][31:0]  var_q;

	logic [7:0]  pad_byte;
	logic [7:0]  byte_in;
	logic [63:0] len_sh;
	logic        len_pos;
	logic [31:0] w0, w1, w9, w14, w_new;
	logic [31:0] t1, t2;
	logic [31:0] ch, maj;

	// Select the next padding byte
	always_comb begin
		len_sh  = bits_q >> {~fill_q[2:0], 3'b000};
		len_pos = (fill_q >= LEN_START) && !pad_extra_q;
		if (!marker_q) begin
			pad_byte = PAD_MARKER;
		end else if (len_pos) begin
			pad_byte = len_sh[7:0];
		end else begin
			pad_byte = 8'h00;
		end
		byte_in = cmd.load_pad ? pad_byte : data_byte;
	end

	assign sts.fill_last = (fill_q == FILL_LAST);
	assign sts.len_byte  = marker_q && len_pos;

	// Schedule taps and one compression round
	always_comb begin
		w0    = line_q[511 -: 32];
		w1    = line_q[479 -: 32];
		w9    = line_q[223 -: 32];
		w14   = line_q[63 -: 32];
		w_new = small_s1(w14) + w9 + small_s0(w1) + w0;
		ch    = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
		maj   = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
		t1    = var_q[7] + big_s1(var_q[4]) + ch + round_k(cmd.rnd) + w0;
		t2    = big_s0(var_q[0]) + maj;
	end

	// Shift bytes in while loading, words while compressing
	always_ff @(posedge clk) begin
		if (cmd.load_data || cmd.load_pad) begin
			line_q <= {line_q[503:0], byte_in};
		end else if (cmd.round) begin
			line_q <= {line_q[479:0], w_new};
		end
	end

	// Track fill, length and padding progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			bits_q      <= '0;
			marker_q    <= 1'b0;
			pad_extra_q <= 1'b0;
		end else if (cmd.init) begin
			fill_q      <= '0;
			bits_q      <= '0;
			marker_q    <= 1'b0;
			pad_extra_q <= 1'b0;
		end else begin
			if (cmd.load_data || cmd.load_pad) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.load_data) begin
				bits_q <= bits_q + BITS_PER_BYTE;
			end
			if (cmd.load_pad) begin
				marker_q <= 1'b1;
				// a marker in the last slot closes its block, so the next one holds the length
				if (!marker_q) begin
					pad_extra_q <= (fill_q >= LEN_START) && (fill_q != FILL_LAST);
				end else if (fill_q == FILL_LAST) begin
					pad_extra_q <= 1'b0;
				end
			end
		end
	end

	// Advance working variables, fold into hash, rotate out digest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= H_INIT;
			var_q  <= H_INIT;
		end else if (cmd.init) begin
			hash_q <= H_INIT;
			var_q  <= H_INIT;
		end else if (cmd.round) begin
			var_q <= {var_q[6], var_q[5], var_q[4], var_q[3] + t1,
				var_q[2], var_q[1], var_q[0], t1 + t2};
		end else if (cmd.add) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + var_q[i];
				var_q[i]  <= hash_q[i] + var_q[i];
			end
		end else if (cmd.out_shift) begin
			hash_q <= {hash_q[0], hash_q[7:1]};
		end
	end

	assign hash_head = hash_q[0];

endmodule

// ----- src/sha_ctrl.sv -----
// Controller: sequences byte loading, padding, rounds and digest output.
// Depends on sha_pkg for the state type and command and status structs.
`timescale 1ns / 1ps

module sha_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           msg_valid,
	input  logic           msg_kind,
	output logic           msg_ready,
	output logic           dig_valid,
	input  logic           dig_ready,
	output logic [2:0]     dig_index,
	input  sha_pkg::sts_t  sts,
	output sha_pkg::cmd_t  cmd
);
	import sha_pkg::*;

	state_t     state_q, state_d;
	logic [5:0] rnd_q, rnd_d;
	logic [2:0] idx_q, idx_d;
	logic       finishing_q, finishing_d;
	logic       final_q, final_d;

	// Hold state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_q       <= '0;
			idx_q       <= '0;
			finishing_q <= 1'b0;
			final_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			rnd_q       <= rnd_d;
			idx_q       <= idx_d;
			finishing_q <= finishing_d;
			final_q     <= final_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d     = state_q;
		rnd_d       = rnd_q;
		idx_d       = idx_q;
		finishing_d = finishing_q;
		final_d     = final_q;
		cmd         = '0;
		cmd.rnd     = rnd_q;
		msg_ready   = 1'b0;
		dig_valid   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				msg_ready = 1'b1;
				if (msg_valid) begin
					if (msg_kind == KIND_DATA) begin
						cmd.load_data = 1'b1;
						if (sts.fill_last) begin
							finishing_d = 1'b0;
							rnd_d       = '0;
							state_d     = ST_ROUND;
						end
					end else begin
						finishing_d = 1'b1;
						state_d     = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.load_pad = 1'b1;
				if (sts.fill_last) begin
					final_d = sts.len_byte;
					rnd_d   = '0;
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				rnd_d     = rnd_q + 6'd1;
				if (rnd_q == ROUND_LAST) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				if (!finishing_q) begin
					state_d = ST_IDLE;
				end else if (final_q) begin
					idx_d   = '0;
					state_d = ST_OUT;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_OUT: begin
				dig_valid = 1'b1;
				if (dig_ready) begin
					cmd.out_shift = 1'b1;
					idx_d         = idx_q + 3'd1;
					if (idx_q == WORD_LAST) begin
						cmd.init    = 1'b1;
						finishing_d = 1'b0;
						state_d     = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign dig_index = idx_q;

endmodule

// ----- src/sha256_stream_hasher.sv -----
// SHA-256 hasher, one byte per input word; eight digest words per finish.
// Data byte: one per cycle while idle; the 64th byte of a block starts 64 rounds, then a fold.
// Input stalls during the rounds and the fold, as there is a single round unit.
// Finish: one cycle per pad byte up to the end of each padded block, then rounds and a fold
// per padded block (one or two blocks), then eight output words; input stalls meanwhile.
// Async reset loads the initial hash value and clears fill and bit count.
`timescale 1ns / 1ps

module sha256_stream_hasher (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           msg_valid,
	output logic           msg_ready,
	input  sha_pkg::msg_t  msg,
	output logic           dig_valid,
	input  logic           dig_ready,
	output sha_pkg::dig_t  dig
);
	import sha_pkg::*;

	cmd_t       cmd;
	sts_t       sts;
	logic [2:0] dig_index;
	logic [31:0] hash_head;

	sha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_kind  (msg.kind),
		.msg_ready (msg_ready),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.dig_index (dig_index),
		.sts       (sts),
		.cmd       (cmd)
	);

	sha_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (msg.data_byte),
		.sts       (sts),
		.hash_head (hash_head)
	);

	// Assemble the output word
	assign dig.digest_word = hash_head;
	assign dig.word_index  = dig_index;
	assign dig.last_word   = (dig_index == WORD_LAST);

endmodule

// ----- src/sha_checker.sv -----
// Port-level checks on the SHA-256 hasher, bound to the top level.
// Depends on sha_pkg for the payload types.
`timescale 1ns / 1ps

module sha_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           msg_valid,
	input logic           msg_ready,
	input sha_pkg::msg_t  msg,
	input logic           dig_valid,
	input logic           dig_ready,
	input sha_pkg::dig_t  dig
);
	import sha_pkg::*;

	// Never take input while a digest word is offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg_ready && dig_valid))
		else $error("input ready while digest word pending");

	// Last flag marks exactly the eighth word
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> (dig.last_word == (dig.word_index == WORD_LAST)))
		else $error("last_word does not match word_index");

	// Words of one digest follow back to back in order
	a_next_word: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && dig_ready && !dig.last_word) |=>
		(dig_valid && (dig.word_index == $past(dig.word_index) + 3'd1)))
		else $error("digest word sequence broken");

	// Digest ends after the last word
	a_end_digest: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && dig_ready && dig.last_word) |=> !dig_valid)
		else $error("digest word after last word");

	// A data byte never produces output on the next cycle
	a_data_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid && msg_ready && (msg.kind == KIND_DATA)) |=> !dig_valid)
		else $error("output after data byte");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.msg_valid (msg_valid),
	.msg_ready (msg_ready),
	.msg       (msg),
	.dig_valid (dig_valid),
	.dig_ready (dig_ready),
	.dig       (dig)
);
